[hw/rtl/plt_pkg.sv]
`timescale 1ns / 1ps
// Package for the piecewise linear table lookup block.
// Table size, field widths, request and status codes, control structs.
package plt_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_W    = 16;
    localparam int COEF_W   = 16;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;
    localparam int IDX_W    = 7;
    localparam int ENTRY_W  = KEY_W + COEF_W;
    localparam int PROD_W   = 2 * COEF_W;

    localparam int DIV_STEPS = COEF_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [COEF_W-1:0] DEFAULT_COEF_RESET = 16'd15401;

    localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_INTERP  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NEAREST = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LOW   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HIGH  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ORDER = 3'd5;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan_run;
        logic mul;
        logic div_start;
        logic out_load;
    } plt_cmd_t;

    typedef struct packed {
        logic direct;
        logic scan_done;
        logic bracket;
        logic div_done;
    } plt_sts_t;

    function automatic logic [IDX_W-1:0] to_point_index(input logic [CNT_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[IDX_W-1:0];
    endfunction

endpackage

[hw/rtl/plt_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module plt_ram #(
    parameter int DEPTH  = 128,
    parameter int DATA_W = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/plt_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for quotients known to fit.
// Depends on plt_pkg.
module plt_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [plt_pkg::PROD_W-1:0]   dividend,
    input  logic [plt_pkg::KEY_W-1:0]    divisor,
    output logic                         done,
    output logic [plt_pkg::COEF_W-1:0]   quotient
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [plt_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [plt_pkg::KEY_W-1:0]       rem_reg;
    logic [plt_pkg::COEF_W-1:0]      low_reg;
    logic [plt_pkg::KEY_W-1:0]       den_reg;

    logic [plt_pkg::KEY_W:0]         trial;
    logic                            ge;
    logic [plt_pkg::KEY_W-1:0]       rem_next;
    logic [plt_pkg::COEF_W-1:0]      low_next;

    always_comb begin
        trial    = {rem_reg, low_reg[plt_pkg::COEF_W-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? plt_pkg::KEY_W'(trial - {1'b0, den_reg}) : trial[plt_pkg::KEY_W-1:0];
        low_next = {low_reg[plt_pkg::COEF_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + plt_pkg::DIV_CNT_W'(1);
                if (cnt_reg == plt_pkg::DIV_CNT_W'(plt_pkg::DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[plt_pkg::PROD_W-1:plt_pkg::COEF_W];
            low_reg <= dividend[plt_pkg::COEF_W-1:0];
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            low_reg <= low_next;
        end
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

[hw/rtl/plt_datapath.sv]
`timescale 1ns / 1ps
// Datapath: point table, count, scan and bracket registers, product, result.
// Depends on plt_pkg, plt_ram and plt_div.
module plt_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [plt_pkg::COEF_W-1:0]      cfg_data,
    input  logic [plt_pkg::REQ_W-1:0]       s_req_type,
    input  logic [plt_pkg::KEY_W-1:0]       s_mach_value,
    input  logic [plt_pkg::COEF_W-1:0]      s_coefficient_in,
    input  plt_pkg::plt_cmd_t               cmd,
    output plt_pkg::plt_sts_t               sts,
    output logic [plt_pkg::COEF_W-1:0]      m_coefficient_out,
    output logic [plt_pkg::STATUS_W-1:0]    m_status,
    output logic [plt_pkg::IDX_W-1:0]       m_point_index
);

    logic [plt_pkg::COEF_W-1:0]   dflt_reg;
    logic [plt_pkg::REQ_W-1:0]    req_reg;
    logic [plt_pkg::KEY_W-1:0]    m_reg;
    logic [plt_pkg::COEF_W-1:0]   c_reg;
    logic [plt_pkg::CNT_W-1:0]    count_reg;
    logic [plt_pkg::KEY_W-1:0]    last_key_reg;
    logic [plt_pkg::COEF_W-1:0]   last_coef_reg;

    logic [plt_pkg::CNT_W-1:0]    iss_reg;
    logic                         ev_valid_reg;
    logic [plt_pkg::CNT_W-1:0]    ev_idx_reg;
    logic [plt_pkg::KEY_W-1:0]    prev_key_reg;
    logic [plt_pkg::COEF_W-1:0]   prev_coef_reg;
    logic [plt_pkg::KEY_W-1:0]    best_diff_reg;
    logic [plt_pkg::CNT_W-1:0]    best_idx_reg;
    logic [plt_pkg::COEF_W-1:0]   best_coef_reg;

    logic [plt_pkg::COEF_W-1:0]   mag_dc_reg;
    logic                         neg_reg;
    logic [plt_pkg::KEY_W-1:0]    dm_reg;
    logic [plt_pkg::KEY_W-1:0]    den_reg;
    logic [plt_pkg::COEF_W-1:0]   base_reg;
    logic [plt_pkg::PROD_W-1:0]   prod_reg;

    logic [plt_pkg::COEF_W-1:0]   res_coef_reg;
    logic [plt_pkg::STATUS_W-1:0] res_status_reg;
    logic [plt_pkg::IDX_W-1:0]    res_idx_reg;

    logic [plt_pkg::ENTRY_W-1:0]  rd_data;
    logic [plt_pkg::KEY_W-1:0]    rd_key;
    logic [plt_pkg::COEF_W-1:0]   rd_coef;
    logic                         rd_en;
    logic                         ram_we;

    logic                         is_interp;
    logic                         is_query;
    logic                         empty;
    logic                         full;
    logic                         order_bad;
    logic                         eval;
    logic                         first;
    logic                         at_end;
    logic                         interp_low;
    logic                         interp_high;
    logic                         take;
    logic [plt_pkg::KEY_W-1:0]    key_gap;
    logic [plt_pkg::CNT_W-1:0]    last_idx;

    logic                         div_done;
    logic [plt_pkg::COEF_W-1:0]   quotient;

    always_comb begin
        rd_key      = rd_data[plt_pkg::ENTRY_W-1:plt_pkg::COEF_W];
        rd_coef     = rd_data[plt_pkg::COEF_W-1:0];
        is_interp   = req_reg == plt_pkg::REQ_INTERP;
        is_query    = is_interp || (req_reg == plt_pkg::REQ_NEAREST);
        empty       = count_reg == '0;
        full        = count_reg == plt_pkg::CNT_W'(plt_pkg::TABLE_DEPTH);
        order_bad   = !empty && (m_reg <= last_key_reg);
        ram_we      = cmd.exec && (req_reg == plt_pkg::REQ_APPEND) && !full && !order_bad;
        rd_en       = cmd.scan_run && (iss_reg < count_reg);
        last_idx    = count_reg - plt_pkg::CNT_W'(1);
        eval        = cmd.scan_run && ev_valid_reg;
        first       = ev_idx_reg == '0;
        at_end      = ev_idx_reg == last_idx;
        interp_low  = m_reg <= rd_key;
        interp_high = m_reg >= last_key_reg;
        key_gap     = (rd_key >= m_reg) ? (rd_key - m_reg) : (m_reg - rd_key);
        take        = first || (key_gap < best_diff_reg);

        sts.direct    = !is_query || empty;
        sts.scan_done = eval && (is_interp ? (first && (interp_low || interp_high)) : at_end);
        sts.bracket   = eval && is_interp && !first && (rd_key >= m_reg);
        sts.div_done  = div_done;
    end

    plt_ram #(
        .DEPTH  (plt_pkg::TABLE_DEPTH),
        .DATA_W (plt_pkg::ENTRY_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[plt_pkg::ADDR_W-1:0]),
        .wdata ({m_reg, c_reg}),
        .raddr (iss_reg[plt_pkg::ADDR_W-1:0]),
        .rdata (rd_data)
    );

    plt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dflt_reg     <= plt_pkg::DEFAULT_COEF_RESET;
            count_reg    <= '0;
            iss_reg      <= '0;
            ev_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                dflt_reg <= cfg_data;
            end
            if (cmd.exec && (req_reg == plt_pkg::REQ_CLEAR)) begin
                count_reg <= '0;
            end else if (ram_we) begin
                count_reg <= count_reg + plt_pkg::CNT_W'(1);
            end
            if (cmd.exec) begin
                iss_reg      <= '0;
                ev_valid_reg <= 1'b0;
            end else if (cmd.scan_run) begin
                if (rd_en) begin
                    iss_reg <= iss_reg + plt_pkg::CNT_W'(1);
                end
                ev_valid_reg <= rd_en;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_req_type;
            m_reg   <= s_mach_value;
            c_reg   <= s_coefficient_in;
        end
        if (ram_we) begin
            last_key_reg  <= m_reg;
            last_coef_reg <= c_reg;
        end
        if (cmd.scan_run) begin
            ev_idx_reg <= iss_reg;
        end
        if (eval) begin
            prev_key_reg  <= rd_key;
            prev_coef_reg <= rd_coef;
            if (take) begin
                best_diff_reg <= key_gap;
                best_idx_reg  <= ev_idx_reg;
                best_coef_reg <= rd_coef;
            end
        end
        if (sts.bracket) begin
            mag_dc_reg <= (rd_coef >= prev_coef_reg) ? (rd_coef - prev_coef_reg)
                                                     : (prev_coef_reg - rd_coef);
            neg_reg    <= rd_coef < prev_coef_reg;
            dm_reg     <= m_reg - prev_key_reg;
            den_reg    <= rd_key - prev_key_reg;
            base_reg   <= prev_coef_reg;
        end
        if (cmd.mul) begin
            prod_reg <= {{plt_pkg::COEF_W{1'b0}}, mag_dc_reg} * {{plt_pkg::KEY_W{1'b0}}, dm_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_coef_reg <= '0;
            res_idx_reg  <= '0;
            case (req_reg)
                plt_pkg::REQ_CLEAR: begin
                    res_status_reg <= plt_pkg::ST_OK;
                end
                plt_pkg::REQ_APPEND: begin
                    if (full) begin
                        res_status_reg <= plt_pkg::ST_FULL;
                    end else if (order_bad) begin
                        res_status_reg <= plt_pkg::ST_ORDER;
                    end else begin
                        res_status_reg <= plt_pkg::ST_OK;
                    end
                end
                default: begin
                    res_coef_reg   <= dflt_reg;
                    res_status_reg <= plt_pkg::ST_EMPTY;
                end
            endcase
        end else if (sts.scan_done) begin
            if (!is_interp) begin
                res_coef_reg   <= take ? rd_coef : best_coef_reg;
                res_status_reg <= plt_pkg::ST_OK;
                res_idx_reg    <= plt_pkg::to_point_index(take ? ev_idx_reg : best_idx_reg);
            end else if (interp_low) begin
                res_coef_reg   <= rd_coef;
                res_status_reg <= plt_pkg::ST_LOW;
                res_idx_reg    <= '0;
            end else begin
                res_coef_reg   <= last_coef_reg;
                res_status_reg <= plt_pkg::ST_HIGH;
                res_idx_reg    <= plt_pkg::to_point_index(last_idx);
            end
        end else if (sts.bracket) begin
            res_status_reg <= plt_pkg::ST_OK;
            res_idx_reg    <= plt_pkg::to_point_index(ev_idx_reg - plt_pkg::CNT_W'(1));
        end else if (div_done) begin
            res_coef_reg <= neg_reg ? (base_reg - quotient) : (base_reg + quotient);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_coefficient_out <= res_coef_reg;
            m_status          <= res_status_reg;
            m_point_index     <= res_idx_reg;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= plt_pkg::CNT_W'(plt_pkg::TABLE_DEPTH))
        else $error("point count beyond table depth");

    a_append_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> count_reg == $past(count_reg) + plt_pkg::CNT_W'(1))
        else $error("table write without count increment");

    a_quot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> quotient <= mag_dc_reg)
        else $error("interpolation step exceeds coefficient span");
`endif

endmodule

[hw/rtl/plt_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: handshakes and sequencing of the datapath.
// Depends on plt_pkg.
module plt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output plt_pkg::plt_cmd_t  cmd,
    input  plt_pkg::plt_sts_t  sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_MUL,
        S_DIVS,
        S_DIV,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;

    always_comb begin
        cmd = '0;
        case (state_reg)
            S_IDLE:   cmd.load      = s_valid;
            S_EXEC:   cmd.exec      = 1'b1;
            S_SCAN:   cmd.scan_run  = 1'b1;
            S_MUL:    cmd.mul       = 1'b1;
            S_DIVS:   cmd.div_start = 1'b1;
            S_FINISH: cmd.out_load  = !m_valid_reg || m_ready;
            default:  cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    state_reg <= sts.direct ? S_FINISH : S_SCAN;
                end
                S_SCAN: begin
                    if (sts.scan_done) begin
                        state_reg <= S_FINISH;
                    end else if (sts.bracket) begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:  state_reg <= S_DIVS;
                S_DIVS: state_reg <= S_DIV;
                S_DIV: begin
                    if (sts.div_done) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (cmd.out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;

endmodule

[hw/rtl/piecewise_linear_table_lookup.sv]
`timescale 1ns / 1ps
// Piecewise linear coefficient table with interpolated and nearest lookup.
// Top level; depends on plt_pkg, plt_ctrl and plt_datapath.
//
// One item is worked on at a time. Clear and append, and any query on an
// empty table, go from the execute state straight to the result. Other
// queries scan the table memory one entry per cycle on its single read
// port; an interpolated query that falls between two points then runs its
// division in a 16-step serial divider after a registered multiply. The
// result sits in an output register, so the next item is accepted while
// it waits. Configuration is always ready; write default_coefficient only
// while idle.
module piecewise_linear_table_lookup (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [plt_pkg::COEF_W-1:0]      cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [plt_pkg::REQ_W-1:0]       s_req_type,
    input  logic [plt_pkg::KEY_W-1:0]       s_mach_value,
    input  logic [plt_pkg::COEF_W-1:0]      s_coefficient_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [plt_pkg::COEF_W-1:0]      m_coefficient_out,
    output logic [plt_pkg::STATUS_W-1:0]    m_status,
    output logic [plt_pkg::IDX_W-1:0]       m_point_index
);

    plt_pkg::plt_cmd_t cmd;
    plt_pkg::plt_sts_t sts;

    assign cfg_ready = 1'b1;

    plt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    plt_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_valid),
        .cfg_data          (cfg_data),
        .s_req_type        (s_req_type),
        .s_mach_value      (s_mach_value),
        .s_coefficient_in  (s_coefficient_in),
        .cmd               (cmd),
        .sts               (sts),
        .m_coefficient_out (m_coefficient_out),
        .m_status          (m_status),
        .m_point_index     (m_point_index)
    );

endmodule
